/* sv/skyline_block_nested_loop_2d_top_defines.svh */
// assertion macros used by the checker
`ifndef SKYLINE_BLOCK_NESTED_LOOP_2D_TOP_DEFINES_SVH
`define SKYLINE_BLOCK_NESTED_LOOP_2D_TOP_DEFINES_SVH

// same-cycle implication
`define SKYBNL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKYBNL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/skybnl_pkg.sv */
package skybnl_pkg;

    typedef struct packed {
        logic kill;
        logic pack_step;
        logic append;
        logic shift;
    } t_cell_ctrl;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EVAL = 4'b0010,
        ST_PACK = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

endpackage

/* sv/skyline_block_nested_loop_2d_top.sv */
// Streaming 2-D skyline filter (maximising dominance) with a window of WINDOW_DEPTH cells.
// Input channel s_axis: one point per item, x/y/index in tdata, tlast marks the
// final point of a set. Output channel m_axis: the surviving points of the set in
// arrival order, x/y/index in tdata, tlast on the final one, tuser set on every
// item of the run if a surviving point was dropped because the window was full.
// Each input point is first checked against the window and dropped when a window
// point beats it; otherwise the cell row closes the gaps left by removed points
// one cell per cycle before the new point is appended, so the block stays busy
// longer the further surviving entries have to move down.
// s_axis_tready is high only while the block waits for a point.
// After the last point the window is sent out one item per cycle straight from
// the first cell; a stalled receiver simply holds the row, nothing is lost.
// After the final item the window is empty and the overflow flag cleared.
// Reset (synchronous, active low) empties the window and clears the flag.
module skyline_block_nested_loop_2d_top #(
    parameter int WINDOW_DEPTH = 32,
    parameter int COORD_WIDTH  = 32,
    parameter int INDEX_WIDTH  = 20,
    localparam int FIELD_W     = 2 * COORD_WIDTH + INDEX_WIDTH,
    localparam int DATA_W      = ((FIELD_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,  // point_x, point_y, point_index
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,  // sky_x, sky_y, sky_index
    output logic              m_axis_tlast,
    output logic              m_axis_tuser   // window_overflow
);
    import skybnl_pkg::*;

    t_state                        r_state;
    t_state                        n_state;
    logic signed [COORD_WIDTH-1:0] r_px;
    logic signed [COORD_WIDTH-1:0] r_py;
    logic [INDEX_WIDTH-1:0]        r_pid;
    logic                          r_last;
    logic                          r_ovf;
    logic                          n_ovf;
    t_cell_ctrl                    w_ctrl;

    logic [WINDOW_DEPTH-1:0]       w_valid;
    logic [WINDOW_DEPTH-1:0]       w_prev_valid;
    logic [WINDOW_DEPTH-1:0]       w_next_valid;
    logic [WINDOW_DEPTH-1:0]       w_beats;
    logic signed [COORD_WIDTH-1:0] w_x [WINDOW_DEPTH];
    logic signed [COORD_WIDTH-1:0] w_y [WINDOW_DEPTH];
    logic [INDEX_WIDTH-1:0]        w_id [WINDOW_DEPTH];
    logic signed [COORD_WIDTH-1:0] w_nx [WINDOW_DEPTH];
    logic signed [COORD_WIDTH-1:0] w_ny [WINDOW_DEPTH];
    logic [INDEX_WIDTH-1:0]        w_nid [WINDOW_DEPTH];

    logic w_in_acc;
    logic w_out_acc;
    logic w_beaten;
    logic w_packed;
    logic w_full;

    assign w_prev_valid = {w_valid[WINDOW_DEPTH-2:0], 1'b1};
    assign w_next_valid = {1'b0, w_valid[WINDOW_DEPTH-1:1]};
    assign w_beaten     = |w_beats;
    assign w_packed     = ~|(~w_valid[WINDOW_DEPTH-2:0] & w_valid[WINDOW_DEPTH-1:1]);
    assign w_full       = w_valid[WINDOW_DEPTH-1];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == ST_EMIT) && w_valid[0];
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;

    assign w_ctrl.kill      = (r_state == ST_EVAL) && !w_beaten;
    assign w_ctrl.pack_step = (r_state == ST_PACK) && !w_packed;
    assign w_ctrl.append    = (r_state == ST_PACK) && w_packed;
    assign w_ctrl.shift     = w_out_acc;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
            if (gi == WINDOW_DEPTH - 1) begin : g_tail
                assign w_nx[gi]  = '0;
                assign w_ny[gi]  = '0;
                assign w_nid[gi] = '0;
            end else begin : g_link
                assign w_nx[gi]  = w_x[gi+1];
                assign w_ny[gi]  = w_y[gi+1];
                assign w_nid[gi] = w_id[gi+1];
            end

            skybnl_cell #(
                .COORD_WIDTH (COORD_WIDTH),
                .INDEX_WIDTH (INDEX_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_px         (r_px),
                .i_py         (r_py),
                .i_pid        (r_pid),
                .i_prev_valid (w_prev_valid[gi]),
                .i_next_valid (w_next_valid[gi]),
                .i_next_x     (w_nx[gi]),
                .i_next_y     (w_ny[gi]),
                .i_next_id    (w_nid[gi]),
                .o_valid      (w_valid[gi]),
                .o_x          (w_x[gi]),
                .o_y          (w_y[gi]),
                .o_id         (w_id[gi]),
                .o_beats      (w_beats[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (w_beaten) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end else begin
                    n_state = ST_PACK;
                end
            end
            ST_PACK: begin
                if (w_packed) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!w_valid[0] || (w_out_acc && m_axis_tlast)) begin
                    n_ovf   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
        if (w_in_acc) begin
            r_px   <= s_axis_tdata[COORD_WIDTH-1:0];
            r_py   <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
            r_pid  <= s_axis_tdata[FIELD_W-1:2*COORD_WIDTH];
            r_last <= s_axis_tlast;
        end
    end

    always_comb begin
        m_axis_tdata                                = '0;
        m_axis_tdata[COORD_WIDTH-1:0]               = w_x[0];
        m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]   = w_y[0];
        m_axis_tdata[FIELD_W-1:2*COORD_WIDTH]       = w_id[0];
    end

    assign m_axis_tlast = !w_valid[1];
    assign m_axis_tuser = r_ovf;

endmodule

/* sv/skybnl_cell.sv */
module skybnl_cell #(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  skybnl_pkg::t_cell_ctrl        i_ctrl,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    input  logic [INDEX_WIDTH-1:0]        i_pid,
    input  logic                          i_prev_valid,
    input  logic                          i_next_valid,
    input  logic signed [COORD_WIDTH-1:0] i_next_x,
    input  logic signed [COORD_WIDTH-1:0] i_next_y,
    input  logic [INDEX_WIDTH-1:0]        i_next_id,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_x,
    output logic signed [COORD_WIDTH-1:0] o_y,
    output logic [INDEX_WIDTH-1:0]        o_id,
    output logic                          o_beats
);
    import skybnl_pkg::*;

    logic                          r_valid;
    logic signed [COORD_WIDTH-1:0] r_x;
    logic signed [COORD_WIDTH-1:0] r_y;
    logic [INDEX_WIDTH-1:0]        r_id;
    logic                          n_valid;
    logic signed [COORD_WIDTH-1:0] n_x;
    logic signed [COORD_WIDTH-1:0] n_y;
    logic [INDEX_WIDTH-1:0]        n_id;
    logic                          w_beaten_by_point;

    assign o_beats = r_valid && (r_x >= i_px) && (r_y >= i_py)
                     && ((r_x > i_px) || (r_y > i_py));
    assign w_beaten_by_point = (i_px >= r_x) && (i_py >= r_y)
                               && ((i_px > r_x) || (i_py > r_y));

    always_comb begin
        n_valid = r_valid;
        n_x     = r_x;
        n_y     = r_y;
        n_id    = r_id;
        if (i_ctrl.shift) begin
            n_valid = i_next_valid;
            n_x     = i_next_x;
            n_y     = i_next_y;
            n_id    = i_next_id;
        end else if (i_ctrl.kill) begin
            if (r_valid && w_beaten_by_point) begin
                n_valid = 1'b0;
            end
        end else if (i_ctrl.pack_step) begin
            // holes drift up, entries drift down one cell a cycle
            if (!r_valid) begin
                n_valid = i_next_valid;
                n_x     = i_next_x;
                n_y     = i_next_y;
                n_id    = i_next_id;
            end else if (!i_prev_valid) begin
                n_valid = 1'b0;
            end
        end else if (i_ctrl.append) begin
            if (!r_valid && i_prev_valid) begin
                n_valid = 1'b1;
                n_x     = i_px;
                n_y     = i_py;
                n_id    = i_pid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_x  <= n_x;
        r_y  <= n_y;
        r_id <= n_id;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_id    = r_id;

endmodule

/* sv/skybnl_checker.sv */
`include "skyline_block_nested_loop_2d_top_defines.svh"

module skybnl_checker #(
    parameter int DATA_W = 88
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast,
    input logic              m_axis_tuser
);

    `SKYBNL_ASSERT_NEXT(a_busy_after_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an accepted item")

    `SKYBNL_ASSERT_IMPL(a_no_input_while_emit, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input ready while results are pending")

    `SKYBNL_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "gap inside an output run")

    `SKYBNL_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid && !m_axis_tuser, "output after the final item of a run")

    `SKYBNL_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output item changed")

endmodule

bind skyline_block_nested_loop_2d_top skybnl_checker #(
    .DATA_W ($bits(m_axis_tdata))
) u_skybnl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* verif/skyline_block_nested_loop_2d_top_tb.sv */
module skyline_block_nested_loop_2d_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = 32;
    localparam int DATA_W        = 88;
    localparam int RANDOM_POINTS = 250;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [19:0]        idx;
        logic               last;
    } t_point;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [19:0]        idx;
        logic               last;
        logic               ovf;
    } t_sky;

    typedef struct packed {
        t_point pt;
        logic   typed;
        t_sky   want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;   // point_x, point_y, point_index
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;   // sky_x, sky_y, sky_index
    logic              m_axis_tlast;
    logic              m_axis_tuser;   // window_overflow

    skyline_block_nested_loop_2d_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // skyline window as the block should hold it
    logic signed [31:0] win_x [DEPTH];
    logic signed [31:0] win_y [DEPTH];
    logic [19:0]        win_id [DEPTH];
    int                 win_count;
    bit                 win_overflow;
    t_sky               pending_sky [$];

    int send_idle_pct;
    int recv_idle_pct;
    int points_sent;
    int runs_done;
    int sky_seen;
    int overflow_runs;
    int mismatches;
    int quiet_cycles;
    int hold_left;
    bit hold_done;

    function automatic bit beats(input logic signed [31:0] ax, ay, bx, by);
        return (ax >= bx) && (ay >= by) && ((ax > bx) || (ay > by));
    endfunction

    function automatic void skyline_absorb(input t_point p, input bit queue_it);
        bit   beaten;
        int   kept;
        int   i;
        t_sky r;
        beaten = 1'b0;
        for (i = 0; i < win_count; i++) begin
            if (beats(win_x[i], win_y[i], p.x, p.y))
                beaten = 1'b1;
        end
        if (!beaten) begin
            kept = 0;
            for (i = 0; i < win_count; i++) begin
                if (!beats(p.x, p.y, win_x[i], win_y[i])) begin
                    win_x[kept]  = win_x[i];
                    win_y[kept]  = win_y[i];
                    win_id[kept] = win_id[i];
                    kept++;
                end
            end
            win_count = kept;
            if (win_count < DEPTH) begin
                win_x[win_count]  = p.x;
                win_y[win_count]  = p.y;
                win_id[win_count] = p.idx;
                win_count++;
            end else begin
                win_overflow = 1'b1;
            end
        end
        if (p.last) begin
            for (i = 0; i < win_count; i++) begin
                r.x    = win_x[i];
                r.y    = win_y[i];
                r.idx  = win_id[i];
                r.last = (i == win_count - 1);
                r.ovf  = win_overflow;
                if (queue_it)
                    pending_sky.push_back(r);
            end
            if (win_overflow)
                overflow_runs++;
            runs_done++;
            win_count    = 0;
            win_overflow = 1'b0;
        end
    endfunction

    function automatic t_row plain(input logic signed [31:0] x, y, input logic [19:0] idx,
                                   input logic last);
        t_row r;
        r       = '0;
        r.pt    = '{x, y, idx, last};
        return r;
    endfunction

    // single-point run: the point comes straight back
    function automatic t_row alone(input logic signed [31:0] x, y, input logic [19:0] idx);
        t_row r;
        r       = '0;
        r.pt    = '{x, y, idx, 1'b1};
        r.typed = 1'b1;
        r.want  = '{x, y, idx, 1'b1, 1'b0};
        return r;
    endfunction

    function automatic logic signed [31:0] pick_coord(input int style);
        case (style)
            0: return $urandom_range(16) - 8;
            1: return $urandom();
            default: begin
                case ($urandom_range(5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h8000_0001;
                    2:       return 32'hffff_ffff;
                    3:       return 32'h0000_0000;
                    4:       return 32'h7fff_fffe;
                    default: return 32'h7fff_ffff;
                endcase
            end
        endcase
    endfunction

    // entered and left on a rising edge; valid stays high after acceptance
    task automatic offer_point(input t_point p, input bit typed, input t_sky want);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, p.idx, p.y, p.x};
        s_axis_tlast  <= p.last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        skyline_absorb(p, !typed);
        if (typed)
            pending_sky.push_back(want);
        points_sent++;
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_sky.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && points_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_sky want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sky_seen++;
            if (pending_sky.size() == 0) begin
                $error("unexpected item: x %0d y %0d index %0d",
                       $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                       m_axis_tdata[83:64]);
                mismatches++;
            end else begin
                want = pending_sky.pop_front();
                if (m_axis_tdata[31:0] !== want.x) begin
                    $error("sky_x: expected %0d, got %0d", want.x, $signed(m_axis_tdata[31:0]));
                    mismatches++;
                end
                if (m_axis_tdata[63:32] !== want.y) begin
                    $error("sky_y: expected %0d, got %0d", want.y, $signed(m_axis_tdata[63:32]));
                    mismatches++;
                end
                if (m_axis_tdata[83:64] !== want.idx) begin
                    $error("sky_index: expected %0d, got %0d", want.idx, m_axis_tdata[83:64]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_result: expected %0d, got %0d", want.last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser !== want.ovf) begin
                    $error("window_overflow: expected %0d, got %0d", want.ovf, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_sky.size());
            $display("skyline_block_nested_loop_2d_top_tb failed");
            $finish;
        end
    end

    initial begin
        t_row   plan [$];
        t_point p;
        int     first_random;
        int     run_no;
        int     run_len;
        int     roll;
        int     k;
        int     phase;
        int     new_phase;
        int     prog;
        int     style;
        bit     flip;
        logic signed [31:0] a;
        logic signed [31:0] swap;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_rst_n       <= 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 70;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, each on its own
        plan.push_back(alone(32'sh7fff_ffff, 32'sh7fff_ffff, 20'hfffff));
        plan.push_back(alone(32'sh8000_0000, 32'sh8000_0000, 20'h00000));
        plan.push_back(alone(32'sh0000_0000, 32'sh0000_0000, 20'h00001));
        // equal points all stay
        plan.push_back(plain(5, 5, 2, 1'b0));
        plan.push_back(plain(5, 5, 3, 1'b0));
        plan.push_back(plain(5, 5, 4, 1'b1));
        // removal, discard, last point beaten
        plan.push_back(plain(1, 1, 5, 1'b0));
        plan.push_back(plain(3, 3, 6, 1'b0));
        plan.push_back(plain(2, 2, 7, 1'b0));
        plan.push_back(plain(3, 3, 8, 1'b0));
        plan.push_back(plain(4, 0, 9, 1'b0));
        plan.push_back(plain(0, 4, 10, 1'b0));
        plan.push_back(plain(4, 4, 11, 1'b0));
        plan.push_back(plain(-1, -1, 12, 1'b1));
        // sign extremes, tie on one coordinate
        plan.push_back(plain(32'sh7fff_ffff, 32'sh8000_0000, 13, 1'b0));
        plan.push_back(plain(32'sh8000_0000, 32'sh7fff_ffff, 14, 1'b0));
        plan.push_back(plain(32'sh8000_0000, 32'sh8000_0000, 15, 1'b1));
        plan.push_back(plain(0, 10, 16, 1'b0));
        plan.push_back(plain(0, 9, 17, 1'b0));
        plan.push_back(plain(0, 11, 18, 1'b1));

        foreach (plan[r])
            offer_point(plan[r].pt, plan[r].typed, plan[r].want);
        pause_until_drained();

        first_random = points_sent;
        run_no = 0;
        phase = 0;
        while (points_sent - first_random < RANDOM_POINTS) begin
            prog = points_sent - first_random;
            new_phase = (prog < RANDOM_POINTS / 3) ? 0 : (prog < 2 * RANDOM_POINTS / 3) ? 1 : 2;
            if (new_phase != phase) begin
                pause_until_drained();
                phase = new_phase;
                send_idle_pct = (phase == 1) ? 70 : 0;
                recv_idle_pct = (phase == 1) ? 26 : 0;
            end
            roll = $urandom_range(99);
            if (run_no == 0 || roll < 20) begin
                // mostly incomparable points to fill the window
                run_len = (run_no == 0) ? 36 : $urandom_range(38, 28);
                flip = $urandom_range(1);
                for (k = 0; k < run_len; k++) begin
                    a   = k * 8 + $urandom_range(7);
                    p.x = a;
                    p.y = -a;
                    if ($urandom_range(9) == 0)
                        p.y = -a + $urandom_range(24);
                    if (flip) begin
                        swap = p.x;
                        p.x  = p.y;
                        p.y  = swap;
                    end
                    p.idx  = $urandom_range(20'hfffff);
                    p.last = (k == run_len - 1);
                    offer_point(p, 1'b0, '0);
                end
            end else begin
                run_len = (roll < 40) ? $urandom_range(8, 1) : $urandom_range(10, 1);
                for (k = 0; k < run_len; k++) begin
                    style  = (roll < 40) ? 1 : (($urandom_range(9) < 7) ? 0 : 2);
                    p.x    = pick_coord(style);
                    style  = (roll < 40) ? 1 : (($urandom_range(9) < 7) ? 0 : 2);
                    p.y    = pick_coord(style);
                    p.idx  = $urandom_range(20'hfffff);
                    p.last = (k == run_len - 1);
                    offer_point(p, 1'b0, '0);
                end
            end
            run_no++;
        end

        pause_until_drained();
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("covered %0d points in %0d runs, %0d skyline items checked",
                 points_sent, runs_done, sky_seen);
        $display("%0d runs overflowed the window, %0d mismatches", overflow_runs, mismatches);
        if (mismatches == 0) begin
            $display("skyline_block_nested_loop_2d_top_tb passed");
        end else begin
            $display("skyline_block_nested_loop_2d_top_tb failed");
        end
        $finish;
    end

endmodule
